FILE: sv/tcp_pkg.sv
// shared types, constants and lookup functions for task class and core placement
// no dependencies
package tcp_pkg;

  localparam int TASK_ENTRIES = 65536;
  localparam int IDX_W        = $clog2(TASK_ENTRIES);

  localparam int DIVIDEND_W = 17;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [7:0]  DEFAULT_CORES = 8'd8;
  localparam logic [9:0]  PERMILLE      = 10'd1000;
  localparam logic [23:0] SLICE_10MS    = 24'd10000000;
  localparam logic [23:0] SLICE_5MS     = 24'd5000000;
  localparam logic [23:0] SLICE_1MS     = 24'd1000000;

  // class codes: bit2 memory, bit1 interactive, bit0 busy
  localparam logic [2:0] CLS_NONE       = 3'd0;
  localparam logic [2:0] CLS_BUSY       = 3'd1;
  localparam logic [2:0] CLS_INTER      = 3'd2;
  localparam logic [2:0] CLS_BUSY_INTER = 3'd3;
  localparam logic [2:0] CLS_MEM        = 3'd4;
  localparam logic [2:0] CLS_MEM_BUSY   = 3'd5;
  localparam logic [2:0] CLS_MEM_INTER  = 3'd6;
  localparam logic [2:0] CLS_ALL        = 3'd7;

  localparam logic [2:0] ELEM_WOOD  = 3'd0;
  localparam logic [2:0] ELEM_FIRE  = 3'd1;
  localparam logic [2:0] ELEM_EARTH = 3'd2;
  localparam logic [2:0] ELEM_METAL = 3'd3;
  localparam logic [2:0] ELEM_WATER = 3'd4;

  typedef enum logic [2:0] {
    REG_CORE_COUNT  = 3'd0,
    REG_FAST_COUNT  = 3'd1,
    REG_BUSY_PERMIL = 3'd2,
    REG_SWITCH_LIM  = 3'd3,
    REG_MEMORY_LIM  = 3'd4,
    REG_HOT_AGE     = 3'd5,
    REG_COLD_AGE    = 3'd6,
    REG_FLIP_AGE    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        task_id;
    logic [63:0]        now_ns;
    logic [63:0]        runtime_ns;
    logic [31:0]        switch_count;
    logic               has_memory;
    logic signed [31:0] resident_pages;
    logic [7:0]         current_core;
  } in_t;

  typedef struct packed {
    logic [2:0]  class_code;
    logic [2:0]  element_code;
    logic [7:0]  target_core;
    logic [3:0]  queue_id;
    logic [23:0] slice_ns;
  } out_t;

  typedef struct packed {
    logic [7:0]  core_count;
    logic [7:0]  fast_core_count;
    logic [9:0]  busy_permille;
    logic [15:0] switch_limit;
    logic [30:0] memory_limit;
    logic [39:0] hot_age_ns;
    logic [39:0] cold_age_ns;
    logic [39:0] flip_age_ns;
  } cfg_t;

  // one table entry; it holds a single stamp
  typedef struct packed {
    logic [63:0] stamp;
    logic [63:0] runtime;
    logic [31:0] switches;
  } ent_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [IDX_W-1:0] addr;
    ent_t             wdata;
  } tbl_req_t;

  function automatic logic [2:0] element_of(input logic [2:0] cls);
    logic [2:0] e;
    case (cls)
      CLS_NONE:       e = ELEM_EARTH;
      CLS_BUSY:       e = ELEM_WOOD;
      CLS_INTER:      e = ELEM_WATER;
      CLS_BUSY_INTER: e = ELEM_METAL;
      CLS_MEM:        e = ELEM_EARTH;
      CLS_MEM_BUSY:   e = ELEM_FIRE;
      CLS_MEM_INTER:  e = ELEM_WOOD;
      default:        e = ELEM_METAL;
    endcase
    return e;
  endfunction

  function automatic logic [23:0] slice_of(input logic [2:0] cls);
    logic [23:0] s;
    case (cls)
      CLS_ALL, CLS_MEM_BUSY: s = SLICE_10MS;
      CLS_NONE, CLS_INTER:   s = SLICE_1MS;
      default:               s = SLICE_5MS;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/tcp_regs.sv
// configuration register file behind the apb-style port
// depends on tcp_pkg
module tcp_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output tcp_pkg::cfg_t      cfg
);
  import tcp_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[5:3]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.core_count      <= 8'd8;
      cfg_r.fast_core_count <= 8'd4;
      cfg_r.busy_permille   <= 10'd500;
      cfg_r.switch_limit    <= 16'd50;
      cfg_r.memory_limit    <= 31'd25600;
      cfg_r.hot_age_ns      <= 40'd50000000;
      cfg_r.cold_age_ns     <= 40'd100000000;
      cfg_r.flip_age_ns     <= 40'd10000000;
    end else if (wr_en) begin
      case (idx)
        REG_CORE_COUNT:  cfg_r.core_count      <= pwdata[7:0];
        REG_FAST_COUNT:  cfg_r.fast_core_count <= pwdata[7:0];
        REG_BUSY_PERMIL: cfg_r.busy_permille   <= pwdata[9:0];
        REG_SWITCH_LIM:  cfg_r.switch_limit    <= pwdata[15:0];
        REG_MEMORY_LIM:  cfg_r.memory_limit    <= pwdata[30:0];
        REG_HOT_AGE:     cfg_r.hot_age_ns      <= pwdata[39:0];
        REG_COLD_AGE:    cfg_r.cold_age_ns     <= pwdata[39:0];
        REG_FLIP_AGE:    cfg_r.flip_age_ns     <= pwdata[39:0];
        default:         cfg_r.core_count      <= cfg_r.core_count;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CORE_COUNT:  prdata = {56'd0, cfg_r.core_count};
      REG_FAST_COUNT:  prdata = {56'd0, cfg_r.fast_core_count};
      REG_BUSY_PERMIL: prdata = {54'd0, cfg_r.busy_permille};
      REG_SWITCH_LIM:  prdata = {48'd0, cfg_r.switch_limit};
      REG_MEMORY_LIM:  prdata = {33'd0, cfg_r.memory_limit};
      REG_HOT_AGE:     prdata = {24'd0, cfg_r.hot_age_ns};
      REG_COLD_AGE:    prdata = {24'd0, cfg_r.cold_age_ns};
      REG_FLIP_AGE:    prdata = {24'd0, cfg_r.flip_age_ns};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: sv/tcp_table.sv
// per-task history memory, one read and one write port, registered read data
// clears itself after reset one entry per cycle; depends on tcp_pkg
module tcp_table (
  input  logic              clk,
  input  logic              rst_n,
  input  tcp_pkg::tbl_req_t req,
  output tcp_pkg::ent_t     rdata,
  output logic              clr_busy
);
  import tcp_pkg::*;

  ent_t             mem [TASK_ENTRIES];
  ent_t             rdata_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic             clr_busy_r;

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(TASK_ENTRIES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.addr];
    end
  end

endmodule

FILE: sv/tcp_div.sv
// iterative remainder unit, one dividend bit per cycle
// depends on tcp_pkg
module tcp_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tcp_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [7:0]                     divisor,
  output logic                           done,
  output logic [7:0]                     remainder
);
  import tcp_pkg::*;

  logic [DIVIDEND_W-1:0] dvd_r;
  logic [7:0]            dvs_r;
  logic [7:0]            rem_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic [8:0]            trial;
  logic [8:0]            diff;

  assign trial     = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign diff      = trial - {1'b0, dvs_r};
  assign done      = done_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(DIVIDEND_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], 1'b0};
      // remainder stays below the divisor, so the low 8 bits hold it
      rem_r <= (trial >= {1'b0, dvs_r}) ? diff[7:0] : trial[7:0];
    end
  end

endmodule

FILE: sv/task_class_and_core_placement_top.sv
// task class and core placement top level: sequencer, classification and core choice
// depends on tcp_pkg, tcp_regs, tcp_table, tcp_div
//
// usage:
//   an item is taken at a rising edge where start is high and busy is low.
//   each item reads its task entry from the history memory, classifies the
//   task, ages the class, writes the entry back and picks a target core.
//   the result appears on out_data for exactly one cycle with out_valid high;
//   the receiver cannot stall, so it must take it in that cycle.
//   out_valid rises after the delta, mul_lo, mul_hi, sum, class and pick states;
//   when the chosen core needs a modulo, the 17-step remainder unit runs first.
//   busy stays high from accept until the cycle after out_valid, so one item
//   is in flight at a time.
//   after reset the history memory is swept to zero, one entry per cycle, over
//   all 65536 entries; busy is high during the sweep. configuration writes on the
//   apb-style port are taken at any time, reads return the register value.
module task_class_and_core_placement_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tcp_pkg::in_t  in_data,
  output logic          out_valid,
  output tcp_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import tcp_pkg::*;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_DELTA  = 11'b00000000100,
    ST_MUL_LO = 11'b00000001000,
    ST_MUL_HI = 11'b00000010000,
    ST_SUM    = 11'b00000100000,
    ST_CLASS  = 11'b00001000000,
    ST_PICK   = 11'b00010000000,
    ST_DIV    = 11'b00100000000,
    ST_OUT    = 11'b01000000000,
    ST_SPARE  = 11'b10000000000
  } state_t;

  state_t   state_r, state_nxt;
  cfg_t     cfg;
  tbl_req_t req;
  ent_t     ent;
  logic     clr_busy;
  logic     accept;

  in_t         item_r;
  logic [63:0] elapsed_r, drt_r;
  logic        sw_bit_r, mem_bit_r;
  logic [41:0] a_lo_r, a_hi_r;
  logic [42:0] b_lo_r, b_hi_r;
  logic [74:0] a_sum_r, b_sum_r;
  logic [2:0]  cls_r;
  logic [7:0]  target_r, offset_r;

  // delta stage
  logic [63:0] elapsed_nxt, drt_nxt, rt_diff;
  logic [31:0] sw_diff;
  logic        sw_bit_nxt, mem_bit_nxt;
  logic [10:0] bp_mult;

  // class stage
  logic        busy_bit;
  logic [2:0]  cls_raw, cls_nxt;

  // pick stage
  logic [7:0]            n_cores, p_half, p_cores, n_minus_p, dvs, off;
  logic                  n_gt_p, cur_lt_p, need_div;
  logic [DIVIDEND_W-1:0] dvd, pid_w, cur_w;
  logic                  div_done;
  logic [7:0]            div_rem;

  tcp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tcp_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rdata    (ent),
    .clr_busy (clr_busy)
  );

  tcp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == ST_PICK && need_div),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign pready = 1'b1;
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    req.rd    = accept;
    req.wr    = (state_r == ST_CLASS);
    req.addr  = (state_r == ST_CLASS) ? item_r.task_id[IDX_W-1:0] : in_data.task_id[IDX_W-1:0];
    req.wdata = '{stamp: item_r.now_ns, runtime: item_r.runtime_ns,
                  switches: item_r.switch_count};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (!clr_busy) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_DELTA;
      ST_DELTA:  state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_CLASS;
      ST_CLASS:  state_nxt = ST_PICK;
      ST_PICK:   state_nxt = need_div ? ST_DIV : ST_OUT;
      ST_DIV:    if (div_done) state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // differences against the stored history; a zero entry means not yet seen
  always_comb begin
    rt_diff     = item_r.runtime_ns - ent.runtime;
    sw_diff     = item_r.switch_count - ent.switches;
    elapsed_nxt = (ent.stamp != '0) ? item_r.now_ns - ent.stamp : '0;
    drt_nxt     = (ent.runtime != '0 && item_r.runtime_ns >= ent.runtime) ? rt_diff : '0;
    sw_bit_nxt  = (ent.switches != '0) && (item_r.switch_count > ent.switches) &&
                  (sw_diff > {16'd0, cfg.switch_limit});
    mem_bit_nxt = item_r.has_memory && !item_r.resident_pages[31] &&
                  (item_r.resident_pages[30:0] > cfg.memory_limit);
    bp_mult     = {1'b0, cfg.busy_permille} + 11'd1;
  end

  // exact busy test and aging
  always_comb begin
    busy_bit = (elapsed_r != '0) && (drt_r != '0) && (a_sum_r >= b_sum_r);
    cls_raw  = {mem_bit_r, sw_bit_r, busy_bit};
    if (cls_raw == CLS_ALL && elapsed_r > {24'd0, cfg.hot_age_ns}) begin
      cls_nxt = CLS_NONE;
    end else if (cls_raw == CLS_NONE && elapsed_r > {24'd0, cfg.cold_age_ns}) begin
      cls_nxt = CLS_ALL;
    end else if (elapsed_r > {24'd0, cfg.flip_age_ns} &&
                 elapsed_r <= {24'd0, cfg.hot_age_ns} &&
                 cls_raw != CLS_NONE && cls_raw != CLS_ALL) begin
      cls_nxt = cls_raw ^ CLS_BUSY;
    end else begin
      cls_nxt = cls_raw;
    end
  end

  // core choice setup: remainder operands and the offset added afterwards
  always_comb begin
    n_cores   = (cfg.core_count != '0) ? cfg.core_count : DEFAULT_CORES;
    p_half    = (cfg.fast_core_count != '0) ? cfg.fast_core_count : {1'b0, n_cores[7:1]};
    p_cores   = (p_half != '0) ? p_half : 8'd1;
    n_gt_p    = n_cores > p_cores;
    n_minus_p = n_cores - p_cores;
    cur_lt_p  = item_r.current_core < p_cores;
    pid_w     = {1'b0, item_r.task_id};
    cur_w     = {{(DIVIDEND_W - 8){1'b0}}, item_r.current_core};
    need_div  = 1'b1;
    dvd       = pid_w;
    dvs       = p_cores;
    off       = '0;
    case (cls_r)
      CLS_ALL: begin
        dvd = pid_w;
      end
      CLS_NONE: begin
        dvs = n_gt_p ? n_minus_p : n_cores;
        off = n_gt_p ? p_cores : 8'd0;
      end
      CLS_BUSY: begin
        need_div = !cur_lt_p;
      end
      CLS_MEM_BUSY: begin
        dvd = pid_w + cur_w;
        dvs = n_cores;
      end
      CLS_MEM_INTER: begin
        dvd = cur_w + 1'b1;
        dvs = n_cores;
      end
      CLS_INTER: begin
        dvd = pid_w ^ cur_w;
        dvs = n_gt_p ? n_minus_p : n_cores;
        off = n_gt_p ? p_cores : 8'd0;
      end
      CLS_MEM: begin
        need_div = 1'b0;
      end
      default: begin
        dvd = cur_lt_p ? cur_w + 1'b1 : pid_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    case (state_r)
      ST_DELTA: begin
        elapsed_r <= elapsed_nxt;
        drt_r     <= drt_nxt;
        sw_bit_r  <= sw_bit_nxt;
        mem_bit_r <= mem_bit_nxt;
      end
      ST_MUL_LO: begin
        a_lo_r <= drt_r[31:0] * PERMILLE;
        b_lo_r <= elapsed_r[31:0] * bp_mult;
      end
      ST_MUL_HI: begin
        a_hi_r <= drt_r[63:32] * PERMILLE;
        b_hi_r <= elapsed_r[63:32] * bp_mult;
      end
      ST_SUM: begin
        a_sum_r <= {1'b0, a_hi_r, 32'd0} + {33'd0, a_lo_r};
        b_sum_r <= {b_hi_r, 32'd0} + {32'd0, b_lo_r};
      end
      ST_CLASS: begin
        cls_r <= cls_nxt;
      end
      ST_PICK: begin
        offset_r <= off;
        target_r <= item_r.current_core;
      end
      ST_DIV: begin
        if (div_done) begin
          target_r <= offset_r + div_rem;
        end
      end
      default: begin
        cls_r <= cls_r;
      end
    endcase
  end

  assign out_valid             = (state_r == ST_OUT);
  assign out_data.class_code   = cls_r;
  assign out_data.element_code = element_of(cls_r);
  assign out_data.target_core  = target_r;
  assign out_data.queue_id     = {1'b0, cls_r} + 4'd1;
  assign out_data.slice_ns     = slice_of(cls_r);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result without an item in flight");

  a_queue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.queue_id == {1'b0, out_data.class_code} + 4'd1)
    else $error("queue id does not follow class");

endmodule
